### rtl/core/htw_pkg.sv
// Package with the transfer types, operation and result codes of the timer wheel.
`default_nettype none
package htw_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = 7;

  localparam logic [1:0] OP_ADD_ONCE     = 2'd0;
  localparam logic [1:0] OP_ADD_PERIODIC = 2'd1;
  localparam logic [1:0] OP_CANCEL       = 2'd2;
  localparam logic [1:0] OP_TICK         = 2'd3;

  localparam logic [1:0] KIND_ADDED  = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_FIRED  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] delay_ticks;
    logic [31:0] timer_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] result_id;
    logic        found;
    logic        last;
  } out_item_t;

  function automatic logic [63:0] low_mask(input int bits);
    logic [63:0] m;
    if (bits >= 64) begin
      m = '1;
    end else begin
      m = (64'd1 << bits) - 64'd1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/core/hierarchical_timer_wheel.sv
// Top level of the hierarchical timer wheel: sequencer, timer table and slot memories.
// Per item: an add files the new timer into a slot (answering full when the table is full), a
// cancel reads the timer table one entry at a time, a tick drains the due level slots from the
// top down and fires or refiles live entries. One item at a time; busy falls in the cycle that
// shows the last result. After reset the slot head memory is cleared, one entry a cycle, over
// all LEVEL_COUNT * 2^SLOT_BITS entries with busy high. The receiver cannot stall the results.
`default_nettype none
module hierarchical_timer_wheel #(
  parameter int MAX_TIMERS  = 64,
  parameter int LEVEL_COUNT = 4,
  parameter int SLOT_BITS   = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire htw_pkg::in_item_t in_data,
  output logic                 busy,
  output logic                 out_valid,
  output htw_pkg::out_item_t   out_data
);

  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int HEAD_W     = $clog2(MAX_TIMERS + 1);
  localparam int LV_W       = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int SA_W       = LV_W + SLOT_BITS;
  localparam int SLOT_TOTAL = LEVEL_COUNT * (1 << SLOT_BITS);
  localparam logic [HEAD_W-1:0] EMPTY = HEAD_W'(MAX_TIMERS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FA   = 4'd2;
  localparam logic [3:0] S_FB   = 4'd3;
  localparam logic [3:0] S_FC   = 4'd4;
  localparam logic [3:0] S_CS   = 4'd5;
  localparam logic [3:0] S_TK   = 4'd6;
  localparam logic [3:0] S_DH   = 4'd7;
  localparam logic [3:0] S_DS   = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_WD   = 4'd10;
  localparam logic [3:0] S_END  = 4'd11;

  logic [31:0]       ident_mem  [MAX_TIMERS];
  logic [63:0]       fire_mem   [MAX_TIMERS];
  logic [31:0]       period_mem [MAX_TIMERS];
  logic [IDX_W-1:0]  link_mem   [MAX_TIMERS];
  logic [HEAD_W-1:0] head_mem   [SLOT_TOTAL];
  logic [IDX_W-1:0]  tail_mem   [SLOT_TOTAL];

  logic [31:0]       ident_rd, period_rd;
  logic [63:0]       fire_rd;
  logic [IDX_W-1:0]  link_rd, tail_rd;
  logic [HEAD_W-1:0] head_rd;

  logic [3:0]             state_r, state_nxt;
  logic [SA_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [63:0]            cur_r, cur_nxt;
  logic [31:0]            next_id_r, next_id_nxt;
  logic [MAX_TIMERS-1:0]  in_use_r, in_use_nxt;
  logic [MAX_TIMERS-1:0]  live_r, live_nxt;
  logic                   out_valid_r, out_valid_nxt;
  htw_pkg::out_item_t     out_data_r, out_data_nxt;
  logic                   pend_v_r, pend_v_nxt;
  htw_pkg::out_item_t     pend_r, pend_nxt;
  logic [htw_pkg::RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                   walk_r, walk_nxt;
  logic [63:0]            ft_r, ft_nxt;
  logic [63:0]            diff_r, diff_nxt;
  logic [IDX_W-1:0]       fe_r, fe_nxt;
  logic [SA_W-1:0]        fslot_r, fslot_nxt;
  logic [SA_W-1:0]        dslot_r, dslot_nxt;
  logic [LV_W-1:0]        lvl_r, lvl_nxt;
  logic [HEAD_W-1:0]      h_r, h_nxt;
  logic [IDX_W-1:0]       t_r, t_nxt;
  logic [HEAD_W-1:0]      cnt_r, cnt_nxt;
  logic [31:0]            id_r, id_nxt;
  logic [HEAD_W-1:0]      cs_cnt_r, cs_cnt_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;

  logic              ent_re;
  logic [IDX_W-1:0]  ent_raddr;
  logic              ident_we, period_we, fire_we, link_we;
  logic [IDX_W-1:0]  ent_waddr, link_waddr;
  logic [31:0]       ident_wdata, period_wdata;
  logic [63:0]       fire_wdata;
  logic [IDX_W-1:0]  link_wdata;
  logic              slot_re;
  logic [SA_W-1:0]   slot_raddr;
  logic              head_we, tail_we;
  logic [SA_W-1:0]   head_waddr, tail_waddr;
  logic [HEAD_W-1:0] head_wdata;
  logic [IDX_W-1:0]  tail_wdata;

  logic               emit_v;
  htw_pkg::out_item_t emit_item;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [31:0]        delay_eff;
  logic [LV_W-1:0]    file_lvl;
  logic [LV_W-1:0]    tick_top;
  logic [IDX_W-1:0]   walk_e;

  function automatic logic [SLOT_BITS-1:0] digit(input logic [63:0] t, input logic [LV_W-1:0] l);
    logic [SLOT_BITS-1:0] d;
    logic [63:0]          sh;
    d = '0;
    for (int k = 0; k < LEVEL_COUNT; k++) begin
      sh = t >> (SLOT_BITS * k);
      if (LV_W'(k) == l && SLOT_BITS * k < 64) begin
        d = sh[SLOT_BITS-1:0];
      end
    end
    return d;
  endfunction

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    file_lvl = '0;
    for (int k = 0; k < LEVEL_COUNT - 1; k++) begin
      if (diff_r > htw_pkg::low_mask(SLOT_BITS * (k + 1))) begin
        file_lvl = LV_W'(k + 1);
      end
    end
  end

  always_comb begin
    logic stop;
    stop     = 1'b0;
    tick_top = '0;
    for (int k = 1; k < LEVEL_COUNT; k++) begin
      if (!stop && (cur_r & htw_pkg::low_mask(SLOT_BITS * k)) == 64'd0) begin
        tick_top = LV_W'(k);
      end else begin
        stop = 1'b1;
      end
    end
  end

  assign delay_eff = (in_data.delay_ticks == 32'd0) ? 32'd1 : in_data.delay_ticks;
  assign walk_e    = h_r[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    next_id_nxt   = next_id_r;
    in_use_nxt    = in_use_r;
    live_nxt      = live_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    res_cnt_nxt   = res_cnt_r;
    walk_nxt      = walk_r;
    ft_nxt        = ft_r;
    diff_nxt      = diff_r;
    fe_nxt        = fe_r;
    fslot_nxt     = fslot_r;
    dslot_nxt     = dslot_r;
    lvl_nxt       = lvl_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    cnt_nxt       = cnt_r;
    id_nxt        = id_r;
    cs_cnt_nxt    = cs_cnt_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    ent_re        = 1'b0;
    ent_raddr     = '0;
    ident_we      = 1'b0;
    period_we     = 1'b0;
    fire_we       = 1'b0;
    link_we       = 1'b0;
    ent_waddr     = '0;
    link_waddr    = '0;
    ident_wdata   = '0;
    period_wdata  = '0;
    fire_wdata    = '0;
    link_wdata    = '0;
    slot_re       = 1'b0;
    slot_raddr    = '0;
    head_we       = 1'b0;
    tail_we       = 1'b0;
    head_waddr    = '0;
    tail_waddr    = '0;
    head_wdata    = '0;
    tail_wdata    = '0;
    emit_v        = 1'b0;
    emit_item     = '0;

    unique case (state_r)
      S_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt_r;
        head_wdata = EMPTY;
        if (clr_cnt_r == SA_W'(SLOT_TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + SA_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          res_cnt_nxt = '0;
          unique case (in_data.op)
            htw_pkg::OP_ADD_ONCE, htw_pkg::OP_ADD_PERIODIC: begin
              if (!free_found) begin
                emit_v         = 1'b1;
                emit_item.kind = htw_pkg::KIND_FULL;
                state_nxt      = S_END;
              end else begin
                in_use_nxt[free_idx] = 1'b1;
                live_nxt[free_idx]   = 1'b1;
                ident_we     = 1'b1;
                period_we    = 1'b1;
                fire_we      = 1'b1;
                ent_waddr    = free_idx;
                ident_wdata  = next_id_r;
                period_wdata = (in_data.op == htw_pkg::OP_ADD_PERIODIC) ? delay_eff : 32'd0;
                fire_wdata   = cur_r + {32'd0, delay_eff};
                ft_nxt       = fire_wdata;
                fe_nxt       = free_idx;
                walk_nxt     = 1'b0;
                state_nxt    = S_FA;
              end
            end
            htw_pkg::OP_CANCEL: begin
              id_nxt     = in_data.timer_id;
              cs_cnt_nxt = '0;
              cmp_v_nxt  = 1'b0;
              state_nxt  = S_CS;
            end
            htw_pkg::OP_TICK: begin
              cur_nxt   = cur_r + 64'd1;
              walk_nxt  = 1'b1;
              state_nxt = S_TK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_FA: begin
        diff_nxt  = (ft_r > cur_r) ? ft_r - cur_r : 64'd0;
        state_nxt = S_FB;
      end
      S_FB: begin
        fslot_nxt  = {file_lvl, digit(ft_r, file_lvl)};
        slot_re    = 1'b1;
        slot_raddr = fslot_nxt;
        state_nxt  = S_FC;
      end
      S_FC: begin
        if (head_rd == EMPTY) begin
          head_we    = 1'b1;
          head_waddr = fslot_r;
          head_wdata = HEAD_W'(fe_r);
        end else begin
          link_we    = 1'b1;
          link_waddr = tail_rd;
          link_wdata = fe_r;
        end
        tail_we    = 1'b1;
        tail_waddr = fslot_r;
        tail_wdata = fe_r;
        if (walk_r) begin
          state_nxt = S_WR;
        end else begin
          emit_v              = 1'b1;
          emit_item.kind      = htw_pkg::KIND_ADDED;
          emit_item.result_id = next_id_r;
          next_id_nxt         = next_id_r + 32'd1;
          state_nxt           = S_END;
        end
      end
      S_CS: begin
        if (cmp_v_r && in_use_r[cmp_idx_r] && live_r[cmp_idx_r] && ident_rd == id_r) begin
          live_nxt[cmp_idx_r] = 1'b0;
          emit_v              = 1'b1;
          emit_item.kind      = htw_pkg::KIND_CANCEL;
          emit_item.result_id = id_r;
          emit_item.found     = 1'b1;
          state_nxt           = S_END;
        end else if (cmp_v_r && cmp_idx_r == IDX_W'(MAX_TIMERS - 1)) begin
          emit_v              = 1'b1;
          emit_item.kind      = htw_pkg::KIND_CANCEL;
          emit_item.result_id = id_r;
          state_nxt           = S_END;
        end else begin
          ent_re      = 1'b1;
          ent_raddr   = cs_cnt_r[IDX_W-1:0];
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = cs_cnt_r[IDX_W-1:0];
          cs_cnt_nxt  = cs_cnt_r + HEAD_W'(1);
        end
      end
      S_TK: begin
        lvl_nxt   = tick_top;
        state_nxt = S_DH;
      end
      S_DH: begin
        dslot_nxt  = {lvl_r, digit(cur_r, lvl_r)};
        slot_re    = 1'b1;
        slot_raddr = dslot_nxt;
        state_nxt  = S_DS;
      end
      S_DS: begin
        h_nxt      = head_rd;
        t_nxt      = tail_rd;
        cnt_nxt    = '0;
        head_we    = 1'b1;
        head_waddr = dslot_r;
        head_wdata = EMPTY;
        state_nxt  = S_WR;
      end
      S_WR: begin
        if (h_r == EMPTY || cnt_r == HEAD_W'(MAX_TIMERS)) begin
          if (lvl_r == '0) begin
            state_nxt = S_END;
          end else begin
            lvl_nxt   = lvl_r - LV_W'(1);
            state_nxt = S_DH;
          end
        end else begin
          ent_re    = 1'b1;
          ent_raddr = walk_e;
          state_nxt = S_WD;
        end
      end
      S_WD: begin
        h_nxt   = (walk_e == t_r) ? EMPTY : HEAD_W'(link_rd);
        cnt_nxt = cnt_r + HEAD_W'(1);
        if (!live_r[walk_e]) begin
          in_use_nxt[walk_e] = 1'b0;
          live_nxt[walk_e]   = 1'b0;
          state_nxt          = S_WR;
        end else if (lvl_r != '0) begin
          ft_nxt    = fire_rd;
          fe_nxt    = walk_e;
          state_nxt = S_FA;
        end else begin
          if (res_cnt_r < htw_pkg::RES_CNT_W'(htw_pkg::MAX_RESULTS)) begin
            emit_v              = 1'b1;
            emit_item.kind      = htw_pkg::KIND_FIRED;
            emit_item.result_id = ident_rd;
            res_cnt_nxt         = res_cnt_r + htw_pkg::RES_CNT_W'(1);
          end
          if (period_rd != 32'd0) begin
            fire_we    = 1'b1;
            ent_waddr  = walk_e;
            fire_wdata = cur_r + {32'd0, period_rd};
            ft_nxt     = fire_wdata;
            fe_nxt     = walk_e;
            state_nxt  = S_FA;
          end else begin
            in_use_nxt[walk_e] = 1'b0;
            live_nxt[walk_e]   = 1'b0;
            state_nxt          = S_WR;
          end
        end
      end
      S_END: begin
        if (pend_v_r) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
          pend_v_nxt        = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit_v) begin
      if (pend_v_r) begin
        out_valid_nxt     = 1'b1;
        out_data_nxt      = pend_r;
        out_data_nxt.last = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (ident_we) begin
      ident_mem[ent_waddr] <= ident_wdata;
    end
    if (period_we) begin
      period_mem[ent_waddr] <= period_wdata;
    end
    if (fire_we) begin
      fire_mem[ent_waddr] <= fire_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ent_re) begin
      ident_rd  <= ident_mem[ent_raddr];
      period_rd <= period_mem[ent_raddr];
      fire_rd   <= fire_mem[ent_raddr];
      link_rd   <= link_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (tail_we) begin
      tail_mem[tail_waddr] <= tail_wdata;
    end
    if (slot_re) begin
      head_rd <= head_mem[slot_raddr];
      tail_rd <= tail_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      cur_r       <= '0;
      next_id_r   <= '0;
      in_use_r    <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_r       <= cur_nxt;
      next_id_r   <= next_id_nxt;
      in_use_r    <= in_use_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
    res_cnt_r  <= res_cnt_nxt;
    walk_r     <= walk_nxt;
    ft_r       <= ft_nxt;
    diff_r     <= diff_nxt;
    fe_r       <= fe_nxt;
    fslot_r    <= fslot_nxt;
    dslot_r    <= dslot_nxt;
    lvl_r      <= lvl_nxt;
    h_r        <= h_nxt;
    t_r        <= t_nxt;
    cnt_r      <= cnt_nxt;
    id_r       <= id_nxt;
    cs_cnt_r   <= cs_cnt_nxt;
    cmp_v_r    <= cmp_v_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the hierarchical timer wheel with a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int NTIMERS   = 64;
  localparam int NSLOTS    = 256;
  localparam int SLOT_SUM  = 4 * NSLOTS;
  localparam int NONE      = NTIMERS;
  localparam int RAND_ITEMS = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  htw_pkg::in_item_t  in_data = '0;
  logic               busy;
  logic               out_valid;
  htw_pkg::out_item_t out_data;

  hierarchical_timer_wheel dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  always #10 clk = ~clk;

  htw_pkg::in_item_t  pending[$];
  htw_pkg::out_item_t results_due[$];
  int        total_items = 0;
  int        accepted = 0;
  int        gap_left = 0;
  int        errors = 0;
  int        n_added = 0, n_full = 0, n_fired = 0, n_hits = 0, n_ticks = 0;

  logic [63:0] now_tick;
  logic [31:0] id_next;
  logic [31:0] tmr_id[NTIMERS];
  logic [63:0] tmr_due[NTIMERS];
  logic [31:0] tmr_period[NTIMERS];
  logic        tmr_live[NTIMERS];
  logic        tmr_used[NTIMERS];
  int          tmr_next[NTIMERS];
  int          wheel_head[SLOT_SUM];
  int          wheel_tail[SLOT_SUM];
  htw_pkg::out_item_t step_out[$];

  function automatic logic [63:0] span_mask(input int bits);
    return (64'd1 << bits) - 64'd1;
  endfunction

  function automatic int wheel_digit(input logic [63:0] t, input int lvl);
    return int'((t >> (8 * lvl)) & 64'hFF);
  endfunction

  function automatic void schedule_timer(input int e);
    logic [63:0] gap;
    int lvl, s;
    gap = (tmr_due[e] > now_tick) ? tmr_due[e] - now_tick : 64'd0;
    lvl = 0;
    while (lvl + 1 < 4 && gap > span_mask(8 * (lvl + 1))) lvl++;
    s = lvl * NSLOTS + wheel_digit(tmr_due[e], lvl);
    if (wheel_head[s] == NONE) wheel_head[s] = e;
    else tmr_next[wheel_tail[s]] = e;
    wheel_tail[s] = e;
  endfunction

  function automatic void report(input logic [1:0] k, input logic [31:0] id, input logic f);
    htw_pkg::out_item_t r;
    if (step_out.size() >= htw_pkg::MAX_RESULTS) return;
    r.kind = k;
    r.result_id = id;
    r.found = f;
    r.last = 1'b0;
    step_out = {step_out, r};
  endfunction

  function automatic void drain_slot(input int s, input logic fire);
    int h, t, e, cnt;
    h = wheel_head[s];
    t = wheel_tail[s];
    wheel_head[s] = NONE;
    for (cnt = 0; cnt < NTIMERS && h < NONE; cnt++) begin
      e = h;
      h = (e == t) ? NONE : tmr_next[e];
      if (!tmr_live[e]) begin
        tmr_used[e] = 1'b0;
      end else if (!fire) begin
        schedule_timer(e);
      end else begin
        report(htw_pkg::KIND_FIRED, tmr_id[e], 1'b0);
        n_fired++;
        if (tmr_period[e] != 0) begin
          tmr_due[e] = now_tick + 64'(tmr_period[e]);
          schedule_timer(e);
        end else begin
          tmr_used[e] = 1'b0;
          tmr_live[e] = 1'b0;
        end
      end
    end
  endfunction

  function automatic void predict_wheel(input htw_pkg::in_item_t it);
    logic [31:0] d;
    int e, top, k;
    logic hit;
    step_out.delete();
    if (it.op == htw_pkg::OP_ADD_ONCE || it.op == htw_pkg::OP_ADD_PERIODIC) begin
      d = (it.delay_ticks == 0) ? 32'd1 : it.delay_ticks;
      for (e = 0; e < NTIMERS && tmr_used[e]; e++) begin end
      if (e >= NTIMERS) begin
        report(htw_pkg::KIND_FULL, 32'd0, 1'b0);
        n_full++;
      end else begin
        tmr_used[e] = 1'b1;
        tmr_live[e] = 1'b1;
        tmr_id[e] = id_next;
        tmr_period[e] = (it.op == htw_pkg::OP_ADD_PERIODIC) ? d : 32'd0;
        tmr_due[e] = now_tick + 64'(d);
        schedule_timer(e);
        report(htw_pkg::KIND_ADDED, id_next, 1'b0);
        id_next++;
        n_added++;
      end
    end else if (it.op == htw_pkg::OP_CANCEL) begin
      hit = 1'b0;
      for (e = 0; e < NTIMERS; e++) begin
        if (tmr_used[e] && tmr_live[e] && tmr_id[e] == it.timer_id) begin
          tmr_live[e] = 1'b0;
          hit = 1'b1;
          break;
        end
      end
      report(htw_pkg::KIND_CANCEL, it.timer_id, hit);
      if (hit) n_hits++;
    end else begin
      n_ticks++;
      now_tick++;
      top = 0;
      for (k = 1; k < 4; k++) begin
        if ((now_tick & span_mask(8 * k)) != 0) break;
        top = k;
      end
      for (k = top; k >= 1; k--) drain_slot(k * NSLOTS + wheel_digit(now_tick, k), 1'b0);
      drain_slot(wheel_digit(now_tick, 0), 1'b1);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    results_due = {results_due, step_out};
  endfunction

  function automatic void queue_item(input logic [1:0] op, input logic [31:0] d,
                                     input logic [31:0] id);
    htw_pkg::in_item_t it;
    it.op = op;
    it.delay_ticks = d;
    it.timer_id = id;
    pending = {pending, it};
    total_items++;
  endfunction

  function automatic logic [31:0] pick_delay(input int heavy);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'd0;
    if (r < 40 - heavy) return 32'($urandom_range(1, 20));
    if (r < 70) return 32'($urandom_range(1, 300));
    if (r < 88) return 32'($urandom_range(256, 70000));
    return $urandom;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_wheel(in_data);
        accepted++;
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending.size() > 0) begin
          in_data <= pending.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    htw_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result kind=%0d id=%h", out_data.kind, out_data.result_id);
      end else begin
        want = results_due.pop_front();
        if (want.kind !== out_data.kind || want.result_id !== out_data.result_id ||
            want.found !== out_data.found || want.last !== out_data.last) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected kind=%0d id=%h found=%b last=%b,",
                     want.kind, want.result_id, want.found, want.last,
                     " got kind=%0d id=%h found=%b last=%b",
                     out_data.kind, out_data.result_id, out_data.found, out_data.last);
        end
      end
    end
  end

  initial begin
    int i, r, adds_made, heavy;
    now_tick = '0;
    id_next = '0;
    for (i = 0; i < NTIMERS; i++) begin
      tmr_used[i] = 1'b0;
      tmr_live[i] = 1'b0;
      tmr_next[i] = 0;
    end
    for (i = 0; i < SLOT_SUM; i++) begin
      wheel_head[i] = NONE;
      wheel_tail[i] = 0;
    end

    queue_item(htw_pkg::OP_ADD_ONCE, 32'd0, 32'd0);
    queue_item(htw_pkg::OP_ADD_PERIODIC, 32'd0, 32'hFFFFFFFF);
    queue_item(htw_pkg::OP_ADD_PERIODIC, 32'd3, 32'd0);
    queue_item(htw_pkg::OP_ADD_ONCE, 32'hFFFFFFFF, 32'd0);
    queue_item(htw_pkg::OP_ADD_ONCE, 32'd255, 32'd0);
    queue_item(htw_pkg::OP_ADD_ONCE, 32'd256, 32'd0);
    queue_item(htw_pkg::OP_ADD_ONCE, 32'd65536, 32'd0);
    queue_item(htw_pkg::OP_ADD_PERIODIC, 32'h01000000, 32'd0);
    queue_item(htw_pkg::OP_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_item(htw_pkg::OP_TICK, 32'd0, 32'd0);
    queue_item(htw_pkg::OP_CANCEL, 32'hFFFFFFFF, 32'd1);
    queue_item(htw_pkg::OP_CANCEL, 32'd0, 32'd1);
    queue_item(htw_pkg::OP_CANCEL, 32'd0, 32'hFFFFFFFF);
    queue_item(htw_pkg::OP_CANCEL, 32'd0, 32'd5);
    queue_item(htw_pkg::OP_TICK, 32'd0, 32'd0);
    queue_item(htw_pkg::OP_TICK, 32'd0, 32'd0);
    queue_item(htw_pkg::OP_TICK, 32'd0, 32'd0);
    queue_item(htw_pkg::OP_TICK, 32'd0, 32'd0);
    queue_item(htw_pkg::OP_CANCEL, 32'd0, 32'd2);
    queue_item(htw_pkg::OP_TICK, 32'd0, 32'd0);
    adds_made = 8;

    for (i = 0; i < RAND_ITEMS; i++) begin
      heavy = (i < 130) ? 25 : 0;
      r = $urandom_range(0, 99);
      if (r < 25 + heavy) begin
        queue_item($urandom_range(0, 1) ? htw_pkg::OP_ADD_PERIODIC : htw_pkg::OP_ADD_ONCE,
                   pick_delay(heavy), $urandom);
        adds_made++;
      end else if (r < 40 + heavy) begin
        queue_item(htw_pkg::OP_CANCEL, $urandom,
                   ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, adds_made)) : $urandom);
      end else begin
        queue_item(htw_pkg::OP_TICK, $urandom, $urandom);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (accepted == total_items);
    @(posedge clk);
    wait (!busy && results_due.size() == 0);
    repeat (20) @(posedge clk);
    $display("Ran %0d items: %0d ticks, %0d adds, %0d table-full answers,", total_items,
             n_ticks, n_added, n_full);
    $display("%0d cancels that hit, %0d timer firings; %0d mismatches.", n_hits, n_fired,
             errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d of %0d items transferred.", accepted, total_items);
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

### hierarchical_timer_wheel.f
rtl/core/htw_pkg.sv
rtl/core/hierarchical_timer_wheel.sv
tb/tb.sv
